>>> src/ps2_device_port_macros.svh
// Assertion helpers for the PS/2 device port.
// With SYNTHESIS defined, every macro expands to nothing.
`ifndef PS2_DEVICE_PORT_MACROS_SVH
`define PS2_DEVICE_PORT_MACROS_SVH

`ifndef SYNTHESIS

`define PS2DP_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ps2dp assertion failed");

`define PS2DP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2dp assertion failed");

`define PS2DP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2dp assertion failed");

`else

`define PS2DP_ASSERT(lbl, clk, rst_n, cond)
`define PS2DP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PS2DP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> src/ps2dp_pkg.sv
package ps2dp_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd40;
    localparam logic [7:0]  RESEND_BYTE     = 8'hFE;

    // Protocol phase codes
    localparam logic [4:0] PH_IDLE      = 5'd0;
    localparam logic [4:0] PH_RX_START  = 5'd1;
    localparam logic [4:0] PH_RX_BIT0   = 5'd2;
    localparam logic [4:0] PH_RX_BIT7   = 5'd9;
    localparam logic [4:0] PH_RX_PARITY = 5'd10;
    localparam logic [4:0] PH_RX_STOP   = 5'd11;
    localparam logic [4:0] PH_RX_END    = 5'd12;
    localparam logic [4:0] PH_TX_START  = 5'd13;
    localparam logic [4:0] PH_TX_BIT0   = 5'd14;
    localparam logic [4:0] PH_TX_BIT7   = 5'd21;
    localparam logic [4:0] PH_TX_PARITY = 5'd22;
    localparam logic [4:0] PH_TX_STOP   = 5'd23;
    localparam logic [4:0] PH_TX_END    = 5'd24;

endpackage

>>> src/ps2_device_port.sv
// PS/2 device-side port. Each input beat is one tick carrying the host's
// open-drain clock and data drives and an optional byte to queue for the host;
// each accepted beat gives exactly one result beat, in order. A beat passes an
// input register and then one step of the protocol logic into the result
// register, so one beat is taken per clock cycle unless i_stall holds the
// result register full. The one exception besides that back-pressure: when a
// host frame ends with a bad stop bit in the same tick as a queue push, the
// 0xFE resend byte takes the single write port of the queue memory in the
// following cycle, and the input is stalled while it does. The generated clock
// runs from a countdown of clock_half_period ticks, written through the
// configuration port (reset 40). The to-host queue holds QUEUE_DEPTH bytes; a
// push into a full queue is dropped and flagged with push_dropped.
`include "ps2_device_port_macros.svh"

module ps2_device_port #(
    parameter int QUEUE_DEPTH = ps2dp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // tick channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_host_clock,
    input  logic        i_host_data,
    input  logic        i_tx_push,
    input  logic [7:0]  i_tx_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_clock_line,
    output logic        o_data_line,
    output logic        o_dev_clock_drive,
    output logic        o_dev_data_drive,
    output logic        o_rx_valid,
    output logic [7:0]  o_rx_byte,
    output logic [4:0]  o_queue_level,
    output logic        o_push_dropped
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);

    function automatic logic [AW-1:0] f_wrap(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        begin
            t = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
            return t[AW-1:0];
        end
    endfunction

    // configuration
    logic [15:0] r_half;

    // input register
    logic        r_in_valid;
    logic        r_in_hclk;
    logic        r_in_hdat;
    logic        r_in_push;
    logic [7:0]  r_in_byte;

    // protocol state
    logic [4:0]    r_phase,  n_phase;
    logic [15:0]   r_cd,     n_cd;
    logic          r_dclk,   n_dclk;
    logic          r_dd,     n_dd;
    logic [7:0]    r_shift,  n_shift;
    logic [3:0]    r_ones,   n_ones;
    logic [CW-1:0] r_count,  n_count;
    logic [AW-1:0] r_head,   n_head;

    // deferred resend-byte write
    logic          r_pend;
    logic [AW-1:0] r_pend_addr;

    // result register
    logic        r_out_valid;
    logic        r_o_clk;
    logic        r_o_dat;
    logic        r_o_dclk;
    logic        r_o_dd;
    logic        r_o_rxv;
    logic [7:0]  r_o_rxb;
    logic [4:0]  r_o_level;
    logic        r_o_drop;

    logic          step_go;
    logic          push_ok;
    logic          dropped;
    logic [CW-1:0] cnt_a;
    logic          rx_flag;
    logic          pop;
    logic          flush;
    logic          fe_push;
    logic          fe_ok;
    logic          do_idle;
    logic          dl;
    logic [7:0]    q_rdata;
    logic [7:0]    pop_data;
    logic          q_we;
    logic [AW-1:0] q_waddr;
    logic [7:0]    q_wdata;
    logic [AW-1:0] q_raddr;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] fe_addr;

    assign step_go     = r_in_valid && !r_pend && (!r_out_valid || !i_stall);
    assign o_stall     = r_in_valid && !step_go;
    assign o_cfg_ready = 1'b1;

    // queue head byte: forwarded from the push of this tick when queue was empty
    assign pop_data = (r_count == '0) ? r_in_byte : q_rdata;

    always_comb begin
        n_phase = r_phase;
        n_cd    = r_cd;
        n_dclk  = r_dclk;
        n_dd    = r_dd;
        n_shift = r_shift;
        n_ones  = r_ones;
        n_head  = r_head;
        rx_flag = 1'b0;
        pop     = 1'b0;
        flush   = 1'b0;
        fe_push = 1'b0;
        do_idle = 1'b0;

        push_ok = r_in_push && (r_count < DEPTH_C);
        dropped = r_in_push && !push_ok;
        cnt_a   = r_count + CW'(push_ok);
        dl      = r_in_hdat & r_dd;

        if ((r_cd != 16'd0) && (!r_dclk || r_in_hclk)) begin
            n_cd = r_cd - 16'd1;
            if (n_cd == 16'd0) begin
                n_dclk = ~r_dclk;
                if (r_dclk) begin
                    n_cd = r_half;
                end
            end
        end else if (!r_dclk) begin
            // device holds clock low, nothing to do
        end else if (!r_in_hclk) begin
            // host inhibit
            n_phase = ps2dp_pkg::PH_IDLE;
            n_cd    = 16'd0;
        end else begin
            case (r_phase)
                ps2dp_pkg::PH_IDLE: begin
                    do_idle = 1'b1;
                end
                ps2dp_pkg::PH_RX_START: begin
                    n_cd    = r_half;
                    n_phase = dl ? ps2dp_pkg::PH_IDLE : ps2dp_pkg::PH_RX_BIT0;
                end
                ps2dp_pkg::PH_RX_PARITY: begin
                    n_cd    = r_half;
                    n_phase = r_phase + 5'd1;
                end
                ps2dp_pkg::PH_RX_STOP: begin
                    if (dl) begin
                        n_dd    = 1'b0;
                        rx_flag = 1'b1;
                    end else begin
                        n_dd    = 1'b1;
                        fe_push = 1'b1;
                    end
                    n_cd    = r_half;
                    n_phase = r_phase + 5'd1;
                end
                ps2dp_pkg::PH_RX_END: begin
                    do_idle = 1'b1;
                end
                ps2dp_pkg::PH_TX_PARITY: begin
                    n_dd    = ~r_ones[0];
                    n_cd    = r_half;
                    n_phase = r_phase + 5'd1;
                end
                ps2dp_pkg::PH_TX_STOP: begin
                    n_dd    = 1'b1;
                    n_cd    = r_half;
                    n_phase = r_phase + 5'd1;
                end
                ps2dp_pkg::PH_TX_END: begin
                    do_idle = 1'b1;
                end
                default: begin
                    if ((r_phase >= ps2dp_pkg::PH_RX_BIT0)
                            && (r_phase <= ps2dp_pkg::PH_RX_BIT7)) begin
                        n_shift = {dl, r_shift[7:1]};
                        n_ones  = r_ones + 4'(dl);
                        n_cd    = r_half;
                        n_phase = r_phase + 5'd1;
                    end else if ((r_phase >= ps2dp_pkg::PH_TX_START)
                            && (r_phase <= ps2dp_pkg::PH_TX_BIT7)) begin
                        n_dd = 1'b1;
                        if (!r_in_hdat) begin
                            // host wants to talk: drop the queue, receive
                            flush   = 1'b1;
                            n_head  = '0;
                            n_cd    = r_half;
                            n_phase = ps2dp_pkg::PH_RX_BIT0;
                        end else begin
                            n_cd    = r_half;
                            n_phase = r_phase + 5'd1;
                            if (r_phase == ps2dp_pkg::PH_TX_START) begin
                                n_dd = 1'b0;
                            end else begin
                                n_dd    = r_shift[0];
                                n_ones  = r_ones + 4'(r_shift[0]);
                                n_shift = {1'b0, r_shift[7:1]};
                            end
                        end
                    end
                end
            endcase
        end

        if (do_idle) begin
            n_dd   = 1'b1;
            n_ones = 4'd0;
            if (!r_in_hdat) begin
                n_cd    = r_half;
                n_phase = ps2dp_pkg::PH_RX_START;
            end else if (cnt_a != '0) begin
                pop     = 1'b1;
                n_shift = pop_data;
                n_head  = f_wrap(SW'(r_head) + SW'(1));
                n_cd    = r_half;
                n_phase = ps2dp_pkg::PH_TX_START;
            end else begin
                n_phase = ps2dp_pkg::PH_IDLE;
            end
        end

        fe_ok = fe_push && (cnt_a < DEPTH_C);

        if (flush) begin
            n_count = '0;
        end else begin
            n_count = cnt_a - CW'(pop) + CW'(fe_ok);
        end
    end

    assign in_addr = f_wrap(SW'(r_head) + SW'(r_count));
    assign fe_addr = f_wrap(SW'(r_head) + SW'(cnt_a));

    always_comb begin
        q_we    = 1'b0;
        q_waddr = in_addr;
        q_wdata = r_in_byte;
        if (r_pend) begin
            q_we    = 1'b1;
            q_waddr = r_pend_addr;
            q_wdata = ps2dp_pkg::RESEND_BYTE;
        end else if (step_go && push_ok) begin
            q_we = 1'b1;
        end else if (step_go && fe_ok) begin
            q_we    = 1'b1;
            q_waddr = fe_addr;
            q_wdata = ps2dp_pkg::RESEND_BYTE;
        end
    end

    assign q_raddr = step_go ? n_head : r_head;

    ps2dp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= ps2dp_pkg::HALF_PERIOD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_half <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_hclk <= i_host_clock;
            r_in_hdat <= i_host_data;
            r_in_push <= i_tx_push;
            r_in_byte <= i_tx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ps2dp_pkg::PH_IDLE;
            r_cd    <= 16'd0;
            r_dclk  <= 1'b1;
            r_dd    <= 1'b1;
            r_shift <= 8'd0;
            r_ones  <= 4'd0;
            r_count <= '0;
            r_head  <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (step_go) begin
                r_phase <= n_phase;
                r_cd    <= n_cd;
                r_dclk  <= n_dclk;
                r_dd    <= n_dd;
                r_shift <= n_shift;
                r_ones  <= n_ones;
                r_count <= n_count;
                r_head  <= n_head;
            end
            // two queue writes in one tick: resend byte goes next cycle
            r_pend <= step_go && push_ok && fe_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_pend_addr <= fe_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_o_clk   <= r_in_hclk & n_dclk;
            r_o_dat   <= r_in_hdat & n_dd;
            r_o_dclk  <= n_dclk;
            r_o_dd    <= n_dd;
            r_o_rxv   <= rx_flag;
            r_o_rxb   <= rx_flag ? r_shift : 8'd0;
            r_o_level <= 5'(n_count);
            r_o_drop  <= dropped;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_clock_line      = r_o_clk;
    assign o_data_line       = r_o_dat;
    assign o_dev_clock_drive = r_o_dclk;
    assign o_dev_data_drive  = r_o_dd;
    assign o_rx_valid        = r_o_rxv;
    assign o_rx_byte         = r_o_rxb;
    assign o_queue_level     = r_o_level;
    assign o_push_dropped    = r_o_drop;

    `PS2DP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= DEPTH_C)
    `PS2DP_ASSERT_IMPL(a_pend_blocks_step, i_clk, i_rst_n, r_pend, !step_go)
    `PS2DP_ASSERT_NEXT(a_pend_one_cycle, i_clk, i_rst_n, r_pend, !r_pend)
    `PS2DP_ASSERT_IMPL(a_ack_drives_data, i_clk, i_rst_n, r_out_valid && r_o_rxv, !r_o_dd)

endmodule

>>> src/ps2dp_queue.sv
// Byte store for the to-host queue: one write port, registered read of the
// next head entry, with the write of the same cycle forwarded.
module ps2dp_queue #(
    parameter int QUEUE_DEPTH = ps2dp_pkg::QUEUE_DEPTH_DEF,
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [QUEUE_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
